@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/gdfw_pkg.sv @@
// package for the depth-first graph walker: sizes, codes and state type
package gdfw_pkg;

  // graph geometry
  localparam int NODES      = 16;
  localparam int MAX_DEGREE = 8;
  localparam int VALUE_BITS = 16;

  // fixed field widths of the channels
  localparam int OP_BITS     = 2;
  localparam int NODE_BITS   = 4;
  localparam int DATA_BITS   = 16;
  localparam int VISIT_BITS  = 16;

  // derived widths
  localparam int CNT_BITS   = $clog2(MAX_DEGREE + 1);
  localparam int ADDR_BITS  = (NODES * MAX_DEGREE > 1) ? $clog2(NODES * MAX_DEGREE) : 1;
  localparam int SP_BITS    = $clog2(NODES);
  localparam int DEPTH_BITS = $clog2(NODES + 1);

  typedef enum logic [OP_BITS-1:0] {
    OP_SET  = 2'd0,
    OP_ADD  = 2'd1,
    OP_WALK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLY,
    S_VISIT,
    S_FETCH,
    S_CHECK,
    S_FINISH
  } state_t;

endpackage

@@ rtl/gdfw_req_if.sv @@
// request channel: one operation per transaction
interface gdfw_req_if;
  import gdfw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_BITS-1:0]   operation;
  logic [NODE_BITS-1:0] node_index;
  logic [NODE_BITS-1:0] target_index;
  logic [DATA_BITS-1:0] node_data;

  modport source (output valid, output operation, output node_index,
                  output target_index, output node_data, input ready);
  modport sink   (input valid, input operation, input node_index,
                  input target_index, input node_data, output ready);
endinterface

@@ rtl/gdfw_rsp_if.sv @@
// response channel: one visit or status result per transaction
interface gdfw_rsp_if;
  import gdfw_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VISIT_BITS-1:0] visit_value;
  logic [NODE_BITS-1:0]  visit_node;
  logic                  status;
  logic                  last;

  modport source (output valid, output visit_value, output visit_node,
                  output status, output last, input ready);
  modport sink   (input valid, input visit_value, input visit_node,
                  input status, input last, output ready);
endinterface

@@ rtl/graph_depth_first_walk.sv @@
// Depth-first graph walker top level: node and edge stores, stack and sequencer
//
// Usage: req carries operation, node_index, target_index and node_data; rsp
// returns visit_value, visit_node, status and last. A transaction moves on
// valid and ready both high. Set value and add edge give one result with
// last = 1; status = 1 means the edge list was full and the edge was dropped.
// A walk clears the visited marks and gives one result per reached node in
// preorder, last = 1 on the final one; a start node out of range gives none.
// req is ready only while the sequencer is idle; a result may still wait in
// the output register while the next request is taken.
// Set value and add edge pass through the reply state into the output register.
// A walk is run by the stack sequencer: a visit per reached node, an
// edge-memory read plus a target check per scanned edge, and a stack pop
// per finished node. Each walk result is held back one visit so that last
// can be marked.
// When rsp stalls, the sequencer waits at the next result with all state held.
// Reset (rst, synchronous) clears node values, edge counts, visited marks,
// stack depth and both channels; the edge memory needs no clearing pass.
`include "assert_macros.svh"

module graph_depth_first_walk
  import gdfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  gdfw_req_if.sink   req,
  gdfw_rsp_if.source rsp
);

  // sequencer state
  state_t state, state_next;

  // latched request
  op_t                  op_r;
  logic [NODE_BITS-1:0] node_r;
  logic [NODE_BITS-1:0] target_r;
  logic [DATA_BITS-1:0] data_r;

  // graph stores
  logic [VALUE_BITS-1:0] node_values [NODES];
  logic [CNT_BITS-1:0]   edge_counts [NODES];
  logic [NODE_BITS-1:0]  edge_mem    [NODES * MAX_DEGREE];
  logic [NODE_BITS-1:0]  mem_rdata;
  logic [NODES-1:0]      visited;

  // walk stack
  logic [NODE_BITS-1:0]  stack_node [NODES];
  logic [CNT_BITS-1:0]   stack_edge [NODES];
  logic [DEPTH_BITS-1:0] depth;
  logic [NODE_BITS-1:0]  cur;

  // result held back one visit
  logic                  pend_valid;
  logic [NODE_BITS-1:0]  pend_node;
  logic [VALUE_BITS-1:0] pend_value;

  // output register
  logic                  out_valid;
  logic [VISIT_BITS-1:0] out_value;
  logic [NODE_BITS-1:0]  out_node;
  logic                  out_status;
  logic                  out_last;

  // datapath signals
  logic                  accept;
  logic                  out_free;
  logic [DEPTH_BITS-1:0] top_full;
  logic [SP_BITS-1:0]    top_idx;
  logic [NODE_BITS-1:0]  top_node;
  logic [CNT_BITS-1:0]   top_edge;
  logic [NODE_BITS-1:0]  cnt_addr;
  logic [CNT_BITS-1:0]   sel_cnt;
  logic                  edge_more;
  logic                  tgt_ok;
  logic                  node_ok;
  logic                  target_ok;
  logic                  list_full;
  logic                  start_ok;
  logic [ADDR_BITS-1:0]  fetch_addr;
  logic [ADDR_BITS-1:0]  add_addr;

  // control from the sequencer outputs
  logic do_reply;
  logic do_visit;
  logic do_flush;
  logic do_fetch;
  logic do_pop;
  logic do_finish;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // stack top and edge count lookup
  assign top_full  = depth - 1'b1;
  assign top_idx   = top_full[SP_BITS-1:0];
  assign top_node  = stack_node[top_idx];
  assign top_edge  = stack_edge[top_idx];
  assign cnt_addr  = (state == S_FETCH) ? top_node : node_r;
  assign sel_cnt   = edge_counts[cnt_addr];
  assign edge_more = (top_edge < sel_cnt) && (32'(top_edge) < MAX_DEGREE);
  assign tgt_ok    = (32'(mem_rdata) < NODES) && !visited[mem_rdata]
                     && (32'(depth) < NODES);

  // range checks for set value, add edge and walk start
  assign node_ok   = 32'(node_r) < NODES;
  assign target_ok = 32'(target_r) < NODES;
  assign list_full = 32'(sel_cnt) >= MAX_DEGREE;
  assign start_ok  = 32'(req.node_index) < NODES;

  // edge memory addresses
  assign fetch_addr = ADDR_BITS'(ADDR_BITS'(top_node) * ADDR_BITS'(MAX_DEGREE))
                      + ADDR_BITS'(top_edge);
  assign add_addr   = ADDR_BITS'(ADDR_BITS'(node_r) * ADDR_BITS'(MAX_DEGREE))
                      + ADDR_BITS'(sel_cnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op_t'(req.operation) == OP_WALK) begin
            state_next = start_ok ? S_VISIT : S_IDLE;
          end else begin
            state_next = S_REPLY;
          end
        end
      end
      S_REPLY:  if (out_free) state_next = S_IDLE;
      S_VISIT:  if (!pend_valid || out_free) state_next = S_FETCH;
      S_FETCH: begin
        if (edge_more) begin
          state_next = S_CHECK;
        end else if (depth == DEPTH_BITS'(1)) begin
          state_next = S_FINISH;
        end
      end
      S_CHECK:  state_next = tgt_ok ? S_VISIT : S_FETCH;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    do_reply  = 1'b0;
    do_visit  = 1'b0;
    do_flush  = 1'b0;
    do_fetch  = 1'b0;
    do_pop    = 1'b0;
    do_finish = 1'b0;
    unique case (state)
      S_IDLE:   ;
      S_REPLY:  do_reply = out_free;
      S_VISIT: begin
        do_visit = !pend_valid || out_free;
        do_flush = pend_valid && out_free;
      end
      S_FETCH: begin
        do_fetch = edge_more;
        do_pop   = !edge_more;
      end
      S_CHECK:  ;
      S_FINISH: do_finish = out_free;
      default:  ;
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(req.operation);
      node_r   <= req.node_index;
      target_r <= req.target_index;
      data_r   <= req.node_data;
    end
  end

  // node values and edge counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        node_values[i] <= '0;
        edge_counts[i] <= '0;
      end
    end else if (do_reply && node_ok) begin
      unique case (op_r)
        OP_SET:  node_values[node_r] <= VALUE_BITS'(data_r);
        OP_ADD:  if (target_ok && !list_full) edge_counts[node_r] <= sel_cnt + 1'b1;
        default: ;
      endcase
    end
  end

  // edge target memory, registered read
  always_ff @(posedge clk) begin
    if (do_reply && op_r == OP_ADD && node_ok && target_ok && !list_full) begin
      edge_mem[add_addr] <= target_r;
    end
    if (do_fetch) begin
      mem_rdata <= edge_mem[fetch_addr];
    end
  end

  // visited marks, stack depth and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      visited    <= '0;
      depth      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (accept && op_t'(req.operation) == OP_WALK) begin
        visited    <= '0;
        depth      <= '0;
        pend_valid <= 1'b0;
      end else if (do_visit) begin
        visited[cur] <= 1'b1;
        depth        <= depth + 1'b1;
        pend_valid   <= 1'b1;
      end else if (do_pop) begin
        depth <= depth - 1'b1;
      end else if (do_finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // stack entries, current node and pending payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req.node_index;
    end else if (state == S_CHECK && tgt_ok) begin
      cur <= mem_rdata;
    end
    if (do_visit) begin
      stack_node[depth[SP_BITS-1:0]] <= cur;
      stack_edge[depth[SP_BITS-1:0]] <= '0;
      pend_node                      <= cur;
      pend_value                     <= node_values[cur];
    end else if (do_fetch) begin
      stack_edge[top_idx] <= top_edge + 1'b1;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_reply || do_flush || do_finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (do_reply) begin
      out_value  <= '0;
      out_node   <= '0;
      out_status <= (op_r == OP_ADD) && node_ok && target_ok && list_full;
      out_last   <= 1'b1;
    end else if (do_flush || do_finish) begin
      out_value  <= VISIT_BITS'(pend_value);
      out_node   <= pend_node;
      out_status <= 1'b0;
      out_last   <= do_finish;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.visit_value = out_value;
  assign rsp.visit_node  = out_node;
  assign rsp.status      = out_status;
  assign rsp.last        = out_last;

  // sequencer and stack checks
  `ASSERT_CLK(a_depth_bound, depth <= DEPTH_BITS'(NODES), "stack depth beyond node count")
  `ASSERT_CLK(a_check_after_fetch, state == S_CHECK |-> $past(state) == S_FETCH,
              "target check without an edge fetch")
  `ASSERT_CLK(a_pend_in_walk,
              (state == S_FETCH || state == S_CHECK || state == S_FINISH) |-> pend_valid,
              "walk running without a pending result")
  `ASSERT_CLK(a_top_visited, state == S_FETCH |-> visited[top_node],
              "stack top node not marked visited")

endmodule
